// ----- rtl/page_table_memory_manager_defines.svh -----
// ----------------------------------------------------------------------------
// Page table memory manager assertion macros
// Shared property forms for the checker of the page table memory manager.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MEMORY_MANAGER_DEFINES_SVH
`define PAGE_TABLE_MEMORY_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled while the reset input is low.
`define PTMM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while the reset input is low.
`define PTMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/ptmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Page table memory manager package
// Geometry constants, beat types, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ptmm_pkg;

    localparam int PAGE_BITS      = 8;
    localparam int NUM_PAGES      = 64;
    localparam int TABLE_PTR_BASE = 64;

    localparam int PG_SIZE = 1 << PAGE_BITS;
    localparam int PIDX_W  = $clog2(NUM_PAGES);
    localparam int ADDR_W  = PAGE_BITS + PIDX_W;
    localparam int IDX_W   = (PAGE_BITS > 6) ? PAGE_BITS : 6;

    localparam logic [1:0] ACT_NEW   = 2'd0;
    localparam logic [1:0] ACT_KILL  = 2'd1;
    localparam logic [1:0] ACT_STORE = 2'd2;
    localparam logic [1:0] ACT_LOAD  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TABLE = 2'd1;
    localparam logic [1:0] ST_NO_DATA  = 2'd2;
    localparam logic [1:0] ST_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  proc_id;
        logic [5:0]  alloc_pages;
        logic [15:0] vaddr;
        logic [7:0]  write_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] phys_addr;
        logic [7:0]  read_value;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_TSCAN_RD, S_TSCAN_CK, S_N_PTR, S_N_LOOP, S_DSCAN_RD, S_DSCAN_CK, S_N_ENT,
        S_K_RD, S_K_CK, S_KE_RD, S_KE_CK, S_K_FREE,
        S_T_RD, S_T_CK, S_T_ERD, S_T_ECK, S_T_ACC, S_T_LD,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        AS_CLR, AS_SLOT, AS_SCAN, AS_IENT, AS_VENT, AS_FLAG_RD, AS_FLAG_TBL, AS_PHYS
    } t_addr_sel;

    typedef enum logic [2:0] {
        WD_CLR, WD_ZERO, WD_ONE, WD_FOUND, WD_WVAL
    } t_wd_sel;

    typedef struct packed {
        t_addr_sel  addr_sel;
        t_wd_sel    wd_sel;
        logic       we;
        logic       ld_in;
        logic       cnt_inc;
        logic       p_inc;
        logic       found;
        logic       ld_table_found;
        logic       ld_table_rd;
        logic       ld_ppage;
        logic       set_st;
        logic [1:0] st_val;
        logic       i_inc;
        logic       ld_rval;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_action;
        logic [1:0] action;
        logic       rd_zero;
        logic       rd_lt;
        logic       p_last;
        logic       pend;
        logic       i_eq_cnt;
        logic       i_last;
        logic       cnt_last;
        logic       out_free;
        logic       vpage_big;
    } t_sts;

endpackage

// ----- rtl/ptmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page table memory manager controller
// Sequences clearing, allocation, kill walks and translations.
// ----------------------------------------------------------------------------
module ptmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ptmm_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output ptmm_pkg::t_cmd o_cmd
);
    import ptmm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:      if (i_sts.cnt_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_sts.in_action)
                        ACT_NEW:  n_state = S_TSCAN_RD;
                        ACT_KILL: n_state = S_K_RD;
                        default:  n_state = S_T_RD;
                    endcase
                end
            end
            S_TSCAN_RD: n_state = i_sts.pend ? S_DONE : S_TSCAN_CK;
            S_TSCAN_CK: begin
                if (i_sts.rd_zero)     n_state = S_N_PTR;
                else if (i_sts.p_last) n_state = S_DONE;
                else                   n_state = S_TSCAN_RD;
            end
            S_N_PTR:    n_state = S_N_LOOP;
            S_N_LOOP:   n_state = i_sts.i_eq_cnt ? S_DONE : S_DSCAN_RD;
            S_DSCAN_RD: n_state = i_sts.pend ? S_DONE : S_DSCAN_CK;
            S_DSCAN_CK: begin
                if (i_sts.rd_zero)     n_state = S_N_ENT;
                else if (i_sts.p_last) n_state = S_DONE;
                else                   n_state = S_DSCAN_RD;
            end
            S_N_ENT:    n_state = S_N_LOOP;
            S_K_RD:     n_state = S_K_CK;
            S_K_CK:     n_state = (i_sts.rd_zero || !i_sts.rd_lt) ? S_DONE : S_KE_RD;
            S_KE_RD:    n_state = S_KE_CK;
            S_KE_CK:    n_state = i_sts.i_last ? S_K_FREE : S_KE_RD;
            S_K_FREE:   n_state = S_DONE;
            S_T_RD:     n_state = S_T_CK;
            S_T_CK:     n_state = (i_sts.vpage_big || !i_sts.rd_lt) ? S_T_ACC : S_T_ERD;
            S_T_ERD:    n_state = S_T_ECK;
            S_T_ECK:    n_state = S_T_ACC;
            S_T_ACC:    n_state = (i_sts.action == ACT_STORE) ? S_DONE : S_T_LD;
            S_T_LD:     n_state = S_DONE;
            S_DONE:     if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_CLR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = AS_SLOT;
        o_cmd.wd_sel   = WD_ZERO;
        o_in_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_CLR: begin
                o_cmd.addr_sel = AS_CLR;
                o_cmd.wd_sel   = WD_CLR;
                o_cmd.we       = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
            end
            S_IDLE: o_cmd.ld_in = i_in_valid;
            S_TSCAN_RD: begin
                o_cmd.addr_sel = AS_SCAN;
                if (i_sts.pend) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = ST_NO_TABLE;
                end
            end
            S_TSCAN_CK, S_DSCAN_CK: begin
                o_cmd.addr_sel = AS_SCAN;
                o_cmd.wd_sel   = WD_ONE;
                if (i_sts.rd_zero) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.found = 1'b1;
                end else if (i_sts.p_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = (r_state == S_TSCAN_CK) ? ST_NO_TABLE : ST_NO_DATA;
                end else begin
                    o_cmd.p_inc = 1'b1;
                end
            end
            S_N_PTR: begin
                o_cmd.wd_sel         = WD_FOUND;
                o_cmd.we             = 1'b1;
                o_cmd.ld_table_found = 1'b1;
            end
            S_N_LOOP: ;
            S_DSCAN_RD: begin
                o_cmd.addr_sel = AS_SCAN;
                if (i_sts.pend) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = ST_NO_DATA;
                end
            end
            S_N_ENT: begin
                o_cmd.addr_sel = AS_IENT;
                o_cmd.wd_sel   = WD_FOUND;
                o_cmd.we       = 1'b1;
                o_cmd.i_inc    = 1'b1;
            end
            S_K_RD: ;
            S_K_CK: begin
                o_cmd.ld_table_rd = 1'b1;
                o_cmd.we          = !i_sts.rd_zero;
            end
            S_KE_RD: o_cmd.addr_sel = AS_IENT;
            S_KE_CK: begin
                // The entry just read names a data page whose flag is dropped, if it is nonzero and in range.
                o_cmd.addr_sel = AS_FLAG_RD;
                o_cmd.we       = !i_sts.rd_zero && i_sts.rd_lt;
                o_cmd.i_inc    = 1'b1;
            end
            S_K_FREE: begin
                o_cmd.addr_sel = AS_FLAG_TBL;
                o_cmd.we       = 1'b1;
            end
            S_T_RD: ;
            S_T_CK: begin
                o_cmd.ld_table_rd = 1'b1;
                if (i_sts.vpage_big || !i_sts.rd_lt) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = ST_UNMAPPED;
                end
            end
            S_T_ERD: o_cmd.addr_sel = AS_VENT;
            S_T_ECK: begin
                if (i_sts.rd_zero || !i_sts.rd_lt) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_val = ST_UNMAPPED;
                end else begin
                    o_cmd.ld_ppage = 1'b1;
                end
            end
            S_T_ACC: begin
                o_cmd.addr_sel = AS_PHYS;
                o_cmd.wd_sel   = WD_WVAL;
                o_cmd.we       = (i_sts.action == ACT_STORE);
            end
            S_T_LD:  o_cmd.ld_rval  = 1'b1;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/ptmm_dp.sv -----
// ----------------------------------------------------------------------------
// Page table memory manager datapath
// Byte store, scan and walk counters, translation registers and result beat.
// ----------------------------------------------------------------------------
module ptmm_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptmm_pkg::t_in_item i_in,
    input  logic               i_out_stall,
    input  ptmm_pkg::t_cmd     i_cmd,
    output ptmm_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output ptmm_pkg::t_out_item o_out
);
    import ptmm_pkg::*;

    logic [7:0] mem [1 << ADDR_W];

    t_in_item          r_in;
    logic [ADDR_W-1:0] r_cnt;
    logic [PIDX_W-1:0] r_p;
    logic              r_pend;
    logic [IDX_W-1:0]  r_i;
    logic [7:0]        r_found;
    logic [7:0]        r_table;
    logic [7:0]        r_ppage;
    logic [1:0]        r_status;
    logic [7:0]        r_rval;
    logic [7:0]        r_rdata;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] phys;
    logic [15:0]       vpage;

    assign vpage = r_in.vaddr >> PAGE_BITS;
    assign phys  = {r_ppage[PIDX_W-1:0], r_in.vaddr[PAGE_BITS-1:0]};

    always_comb begin
        unique case (i_cmd.addr_sel)
            AS_CLR:      addr = r_cnt;
            AS_SLOT:     addr = ADDR_W'(TABLE_PTR_BASE) + ADDR_W'(r_in.proc_id);
            AS_SCAN:     addr = ADDR_W'(r_p);
            AS_IENT:     addr = {r_table[PIDX_W-1:0], r_i[PAGE_BITS-1:0]};
            AS_VENT:     addr = {r_table[PIDX_W-1:0], vpage[PAGE_BITS-1:0]};
            AS_FLAG_RD:  addr = ADDR_W'(r_rdata);
            AS_FLAG_TBL: addr = ADDR_W'(r_table);
            AS_PHYS:     addr = phys;
            default:     addr = r_cnt;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wd_sel)
            WD_CLR:   wdata = (r_cnt == '0) ? 8'd1 : 8'd0;
            WD_ZERO:  wdata = 8'd0;
            WD_ONE:   wdata = 8'd1;
            WD_FOUND: wdata = r_found;
            WD_WVAL:  wdata = r_in.write_value;
            default:  wdata = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[addr] <= wdata;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in     <= i_in;
            r_p      <= PIDX_W'(1);
            r_pend   <= 1'b0;
            r_i      <= '0;
            r_ppage  <= '0;
            r_status <= ST_OK;
            r_rval   <= '0;
        end else begin
            if (i_cmd.p_inc) r_p <= r_p + 1'b1;
            if (i_cmd.found) begin
                // Every lower page is used now, so the next search resumes above.
                r_found <= 8'(r_p);
                if (r_p == PIDX_W'(NUM_PAGES - 1)) r_pend <= 1'b1;
                else r_p <= r_p + 1'b1;
            end
            if (i_cmd.ld_table_found) r_table <= r_found;
            if (i_cmd.ld_table_rd) r_table <= r_rdata;
            if (i_cmd.ld_ppage) r_ppage <= r_rdata;
            if (i_cmd.set_st) r_status <= i_cmd.st_val;
            if (i_cmd.i_inc) r_i <= r_i + 1'b1;
            if (i_cmd.ld_rval) r_rval <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status     <= r_status;
            r_out.phys_addr  <= r_in.action[1] ? 14'(phys) : 14'd0;
            r_out.read_value <= r_rval;
        end
    end

    assign o_sts.in_action = i_in.action;
    assign o_sts.action    = r_in.action;
    assign o_sts.rd_zero   = (r_rdata == 8'd0);
    assign o_sts.rd_lt     = ({1'b0, r_rdata} < 9'(NUM_PAGES));
    assign o_sts.p_last    = (r_p == PIDX_W'(NUM_PAGES - 1));
    assign o_sts.pend      = r_pend;
    assign o_sts.i_eq_cnt  = (r_i == IDX_W'(r_in.alloc_pages));
    assign o_sts.i_last    = &r_i[PAGE_BITS-1:0];
    assign o_sts.cnt_last  = &r_cnt;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.vpage_big = (vpage >= 16'(PG_SIZE));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/page_table_memory_manager.sv -----
// ----------------------------------------------------------------------------
// Page table memory manager
// Paged byte store with per-process single-level tables and a used-page map.
// ----------------------------------------------------------------------------
// Usage: one input beat (action, process, page count, address, byte) gives
// exactly one result beat (status, physical address, read byte).
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The block works on one beat at a time and stalls its input until
// the result is loaded into the output register.
// All work goes through one single-port byte memory. A store or load that is
// found unmapped early skips the table entry read; a kill with no valid table
// stops after the slot check, else it walks every entry of the table; a new
// process scans the used-page map for a table page, then for each data page.
// At reset a clearing pass writes the whole store with the input stalled;
// byte 0 is set to one on the way.
// A stalled result holds in the output register; a further input beat is
// accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module page_table_memory_manager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptmm_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptmm_pkg::t_out_item o_out
);
    import ptmm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ptmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/ptmm_checker.sv -----
// ----------------------------------------------------------------------------
// Page table memory manager checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_table_memory_manager_defines.svh"

module ptmm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input ptmm_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ptmm_pkg::t_out_item o_out
);
    import ptmm_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // The clearing pass keeps the input stalled right after reset.
    `PTMM_ASSERT_NEXT(a_reset_stall, i_clk, 1'b1, !i_rst_n, o_in_stall)
    // Only one beat is in work: the input stalls after an accept.
    `PTMM_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, in_acc, o_in_stall)
    // The beat is still in work after accept, so no result appears right after it.
    `PTMM_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, in_acc, !$rose(o_out_valid))
    // A stalled result beat holds.
    `PTMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out))

endmodule

bind page_table_memory_manager ptmm_checker u_ptmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ----- tb/sv/tb_page_table_memory_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table memory manager testbench
// Drives process creation, kill, byte store and byte load beats with random
// idling on both channels, mirrors the paged store in a local copy and checks
// every result beat field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb_page_table_memory_manager;
    import ptmm_pkg::*;

    localparam int STORE_BYTES = NUM_PAGES << PAGE_BITS;
    localparam int RANDOM_BEATS = 1630;
    localparam longint CYCLE_LIMIT = 6000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    page_table_memory_manager dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    logic [7:0] mirror_mem [STORE_BYTES];
    t_in_item   cmd_q [$];
    t_out_item  result_q [$];
    int         total_beats;
    int         sent_beats;
    int         fail_count;
    longint     cycle_count;
    logic       in_taken;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [13:0] byte_addr(int page, int off);
        return 14'((page << PAGE_BITS) | (off & (PG_SIZE - 1)));
    endfunction

    function automatic int grab_free_page();
        for (int p = 1; p < NUM_PAGES; p++) begin
            if (mirror_mem[p] == 8'd0) begin
                mirror_mem[p] = 8'd1;
                return p;
            end
        end
        return 0;
    endfunction

    function automatic t_out_item translate_beat(t_in_item it);
        t_out_item r;
        int slot;
        int table_pg;
        int data_pg;
        int vpage;
        int ppage;
        int e;
        r = '0;
        slot = (TABLE_PTR_BASE + it.proc_id) % STORE_BYTES;
        case (it.action)
            ACT_NEW: begin
                table_pg = grab_free_page();
                if (table_pg == 0) begin
                    r.status = ST_NO_TABLE;
                end else begin
                    mirror_mem[slot] = 8'(table_pg);
                    for (int i = 0; i < it.alloc_pages; i++) begin
                        data_pg = grab_free_page();
                        if (data_pg == 0) begin
                            r.status = ST_NO_DATA;
                            break;
                        end
                        mirror_mem[byte_addr(table_pg, i)] = 8'(data_pg);
                    end
                end
            end
            ACT_KILL: begin
                table_pg = mirror_mem[slot];
                if (table_pg != 0) begin
                    mirror_mem[slot] = 8'd0;
                    if (table_pg < NUM_PAGES) begin
                        for (int i = 0; i < PG_SIZE; i++) begin
                            e = mirror_mem[byte_addr(table_pg, i)];
                            if (e != 0 && e < NUM_PAGES) mirror_mem[e] = 8'd0;
                        end
                        mirror_mem[table_pg] = 8'd0;
                    end
                end
            end
            default: begin
                table_pg = mirror_mem[slot];
                vpage = it.vaddr >> PAGE_BITS;
                ppage = 0;
                if (vpage >= PG_SIZE || table_pg >= NUM_PAGES) begin
                    r.status = ST_UNMAPPED;
                end else begin
                    ppage = mirror_mem[byte_addr(table_pg, vpage)];
                    if (ppage == 0 || ppage >= NUM_PAGES) begin
                        ppage = 0;
                        r.status = ST_UNMAPPED;
                    end
                end
                r.phys_addr = byte_addr(ppage, it.vaddr);
                if (it.action == ACT_STORE) mirror_mem[r.phys_addr] = it.write_value;
                else r.read_value = mirror_mem[r.phys_addr];
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] act, int pid, int cnt, int va, int wv);
        t_in_item it;
        it.action = act;
        it.proc_id = 6'(pid);
        it.alloc_pages = 6'(cnt);
        it.vaddr = 16'(va);
        it.write_value = 8'(wv);
        return it;
    endfunction

    // Mostly well-formed traffic on a few processes with small page counts and
    // low virtual pages, with some fully random beats mixed in.
    function automatic t_in_item random_cmd();
        t_in_item it;
        int pick;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        if ($urandom_range(99) < 12) return it;
        pick = $urandom_range(99);
        if (pick < 20) it.action = ACT_NEW;
        else if (pick < 34) it.action = ACT_KILL;
        else if (pick < 67) it.action = ACT_STORE;
        else it.action = ACT_LOAD;
        it.proc_id = 6'($urandom_range(7));
        it.alloc_pages = ($urandom_range(19) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(6));
        it.vaddr = {8'($urandom_range(7)), 8'($urandom)};
        return it;
    endfunction

    function automatic int phase_of(int n);
        return (n * 3) / total_beats;
    endfunction

    // Input driver and receiver stall, both updated on the falling edge.
    always @(negedge i_clk) begin
        int ph;
        ph = phase_of(sent_beats);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (ph == 0) i_out_stall <= ($urandom_range(99) < 67);
            else if (ph == 1) i_out_stall <= ($urandom_range(99) < 27);
            else i_out_stall <= 1'b0;
            if (!i_in_valid || in_taken) begin
                if (cmd_q.size() == 0 ||
                    ((sent_beats == total_beats / 3 || sent_beats == 2 * total_beats / 3)
                     && result_q.size() != 0) ||
                    (ph == 0 && $urandom_range(99) < 27) ||
                    (ph == 1 && $urandom_range(99) < 67)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in <= cmd_q.pop_front();
                    sent_beats <= sent_beats + 1;
                end
            end
        end
    end

    // Monitor: predicts on every accepted input beat, checks every result beat.
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) result_q.push_back(translate_beat(i_in));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out);
                fail_count <= fail_count + 1;
            end else begin
                want = result_q.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out.status);
                    fail_count <= fail_count + 1;
                end
                if (o_out.phys_addr !== want.phys_addr) begin
                    $error("phys_addr expected %0h actual %0h", want.phys_addr,
                           o_out.phys_addr);
                    fail_count <= fail_count + 1;
                end
                if (o_out.read_value !== want.read_value) begin
                    $error("read_value expected %0h actual %0h", want.read_value,
                           o_out.read_value);
                    fail_count <= fail_count + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in = '0;
        in_taken = 1'b0;
        sent_beats = 0;
        fail_count = 0;
        cycle_count = 0;
        for (int a = 0; a < STORE_BYTES; a++) mirror_mem[a] = 8'd0;
        mirror_mem[0] = 8'd1;

        // Directed part: reset state, mapping, unmapped and wide addresses,
        // running out of data pages and of table pages, and kills.
        cmd_q.push_back(make_cmd(ACT_LOAD, 0, 0, 16'h0000, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 5, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_NEW, 0, 3, 0, 0));
        cmd_q.push_back(make_cmd(ACT_STORE, 0, 0, 16'h01ff, 8'hff));
        cmd_q.push_back(make_cmd(ACT_LOAD, 0, 0, 16'h01ff, 0));
        cmd_q.push_back(make_cmd(ACT_STORE, 0, 0, 16'h0500, 8'h00));
        cmd_q.push_back(make_cmd(ACT_LOAD, 0, 0, 16'hffff, 0));
        cmd_q.push_back(make_cmd(ACT_STORE, 63, 0, 16'h0042, 8'h5a));
        cmd_q.push_back(make_cmd(ACT_NEW, 63, 63, 0, 0));
        cmd_q.push_back(make_cmd(ACT_NEW, 1, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_LOAD, 1, 0, 16'h0000, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 63, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_NEW, 2, 63, 0, 0));
        cmd_q.push_back(make_cmd(ACT_NEW, 2, 1, 0, 0));
        cmd_q.push_back(make_cmd(ACT_LOAD, 2, 0, 16'h3a10, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 2, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 2, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 0, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_KILL, 1, 0, 0, 0));
        cmd_q.push_back(make_cmd(ACT_NEW, 3, 2, 0, 0));
        cmd_q.push_back(make_cmd(ACT_LOAD, 3, 0, 16'h0100, 0));
        for (int n = 0; n < RANDOM_BEATS; n++) cmd_q.push_back(random_cmd());
        total_beats = cmd_q.size();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (cmd_q.size() == 0 && !i_in_valid);
        wait (result_q.size() == 0);
        repeat (1200) @(posedge i_clk);
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- page_table_memory_manager.f -----
+incdir+rtl
rtl/ptmm_pkg.sv
rtl/ptmm_ctrl.sv
rtl/ptmm_dp.sv
rtl/page_table_memory_manager.sv
rtl/ptmm_checker.sv
tb/sv/tb_page_table_memory_manager.sv
